@@ sv/tsgt_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and codes for the TDMA slot grid table.
// Used by tdma_slot_grid_table; depends on nothing else.
package tsgt_pkg;

    localparam int MAX_RESULTS = 64;
    localparam int CNT_W       = 7;

    // Slot states.
    localparam logic [2:0] ST_FREE = 3'd0;
    localparam logic [2:0] ST_PTX  = 3'd1;
    localparam logic [2:0] ST_PRX  = 3'd2;
    localparam logic [2:0] ST_TX   = 3'd3;
    localparam logic [2:0] ST_RX   = 3'd4;
    localparam logic [2:0] ST_RES  = 3'd5;

    // Commands.
    localparam logic [3:0] CMD_QUERY     = 4'd0;
    localparam logic [3:0] CMD_PROPOSE   = 4'd1;
    localparam logic [3:0] CMD_CONFIRM   = 4'd2;
    localparam logic [3:0] CMD_RESERVE   = 4'd3;
    localparam logic [3:0] CMD_FREE      = 4'd4;
    localparam logic [3:0] CMD_MARK_RM   = 4'd5;
    localparam logic [3:0] CMD_UPDATE    = 4'd6;
    localparam logic [3:0] CMD_ABORT_RM  = 4'd7;
    localparam logic [3:0] CMD_ABORT_RX  = 4'd8;
    localparam logic [3:0] CMD_ABORT_TX  = 4'd9;
    localparam logic [3:0] CMD_EXEC_RM   = 4'd10;
    localparam logic [3:0] CMD_IDLE_SCAN = 4'd11;

    // Configuration register indexes.
    localparam logic [2:0] CFG_USED_T  = 3'd0;
    localparam logic [2:0] CFG_USED_F  = 3'd1;
    localparam logic [2:0] CFG_TX_TO   = 3'd2;
    localparam logic [2:0] CFG_RX_TO   = 3'd3;
    localparam logic [2:0] CFG_SHARE   = 3'd4;

    typedef struct packed {
        logic [2:0]  st;
        logic [63:0] partner;
        logic [63:0] last_use;
        logic [63:0] removal;
    } t_cell;

    typedef struct packed {
        logic        ok;
        logic        oor;
        logic [2:0]  status;
        logic [63:0] partner;
        logic        rm_pend;
        logic        av_tx;
        logic        av_rx;
        logic        col_free;
        logic [2:0]  ft;
        logic [2:0]  ff;
        logic        last;
    } t_res;

endpackage

@@ sv/tdma_slot_grid_table.sv @@
`timescale 1ns / 1ps
// Slot table for a multi-frequency TDMA MAC: sequencer, cell memory, result register.
// Depends on tsgt_pkg.

// One request at a time passes through a small sequencer over a single-port cell memory
// (one read or one write a cycle, read data registered). Every cell visit is a read state
// and an evaluate state. An addressed request walks its timeslot twice (before and after
// the update). Removal and proposal aborts walk the grid cell by cell and then, on a
// match, the reported timeslot. The idle scan walks the grid cell by cell. A full result
// register that is held off stalls the sequencer. After reset the memory is cleared one
// cell a cycle, all MAX_TIMESLOTS*MAX_FREQSLOTS cells, while no request is taken;
// configuration writes are accepted during that time.
module tdma_slot_grid_table #(
    parameter int MAX_TIMESLOTS = 8,
    parameter int MAX_FREQSLOTS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [47:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [3:0]  i_command,
    input  logic [7:0]  i_timeslot,
    input  logic [7:0]  i_freqslot,
    input  logic [2:0]  i_slot_kind,
    input  logic [63:0] i_partner_id,
    input  logic [63:0] i_removal_id,
    input  logic [63:0] i_now_ns,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_ok,
    output logic        o_out_of_range,
    output logic [2:0]  o_slot_status,
    output logic [63:0] o_slot_partner,
    output logic        o_removal_pending,
    output logic        o_avail_tx,
    output logic        o_avail_rx,
    output logic        o_column_free,
    output logic [2:0]  o_found_timeslot,
    output logic [2:0]  o_found_freqslot,
    output logic        o_last
);

    localparam int CELLS = MAX_TIMESLOTS * MAX_FREQSLOTS;
    localparam int TW    = (MAX_TIMESLOTS > 1) ? $clog2(MAX_TIMESLOTS) : 1;
    localparam int FW    = (MAX_FREQSLOTS > 1) ? $clog2(MAX_FREQSLOTS) : 1;
    localparam int CW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int NTW   = $clog2(MAX_TIMESLOTS + 1);
    localparam int NFW   = $clog2(MAX_FREQSLOTS + 1);

    typedef enum logic [12:0] {
        S_CLEAR = 13'b0000000000001,
        S_IDLE  = 13'b0000000000010,
        S_CRD   = 13'b0000000000100,
        S_CEV   = 13'b0000000001000,
        S_ACT   = 13'b0000000010000,
        S_RRD   = 13'b0000000100000,
        S_REV   = 13'b0000001000000,
        S_OUT   = 13'b0000010000000,
        S_SRD   = 13'b0000100000000,
        S_SEV   = 13'b0001000000000,
        S_IRD   = 13'b0010000000000,
        S_IEV   = 13'b0100000000000,
        S_IFIN  = 13'b1000000000000
    } t_state;

    t_state r_state;

    // Configuration.
    logic [3:0]  r_used_t;
    logic [3:0]  r_used_f;
    logic [47:0] r_tx_to;
    logic [47:0] r_rx_to;
    logic        r_share;

    // Request and sequencer registers.
    logic [3:0]  r_cmd;
    logic [2:0]  r_kind;
    logic [63:0] r_mac;
    logic [63:0] r_rid;
    logic [63:0] r_now;
    logic [TW-1:0] r_t, r_tt, r_ft;
    logic [FW-1:0] r_f, r_tf, r_ff;
    logic [CW-1:0] r_clr;
    logic        r_found, r_ok, r_oor, r_have;
    logic        r_nonfree, r_res, r_txl, r_rxl, r_ptxbad;
    tsgt_pkg::t_cell r_cell;
    tsgt_pkg::t_res r_pend;
    logic        r_pv;
    logic [tsgt_pkg::CNT_W-1:0] r_cnt;
    tsgt_pkg::t_res r_out;
    logic        r_ovalid;

    // Cell memory.
    tsgt_pkg::t_cell mem [CELLS];
    tsgt_pkg::t_cell r_rd;
    logic            mem_we, rd_en;
    logic [CW-1:0]   mem_wa, rd_a;
    tsgt_pkg::t_cell mem_wd;

    logic [NTW-1:0] nt;
    logic [NFW-1:0] nf;
    logic           f_end, t_end, cell_end, grid_empty, out_free, accept;
    logic           mac_eq, av_tx, av_rx;
    logic           n_nonfree, n_res, n_txl, n_rxl, n_ptxbad;
    logic           act_ok, act_we, sw_hit, idle_hit;
    tsgt_pkg::t_cell act_wd, sw_wd;
    tsgt_pkg::t_res  res_rep, res_idle;
    logic [2:0]     s;
    logic [63:0]    lim, idle_age;
    logic           in_oor;
    logic           out_load;
    tsgt_pkg::t_res out_word;

    function automatic logic [CW-1:0] cix(input logic [TW-1:0] t, input logic [FW-1:0] f);
        return CW'(t) * CW'(MAX_FREQSLOTS) + CW'(f);
    endfunction

    assign nt = ({4'b0, r_used_t} > 8'(MAX_TIMESLOTS)) ? NTW'(MAX_TIMESLOTS) : NTW'(r_used_t);
    assign nf = ({4'b0, r_used_f} > 8'(MAX_FREQSLOTS)) ? NFW'(MAX_FREQSLOTS) : NFW'(r_used_f);
    assign grid_empty = (nt == '0) || (nf == '0);
    assign f_end      = (NFW'(r_f) == nf - NFW'(1));
    assign t_end      = (NTW'(r_t) == nt - NTW'(1));
    assign cell_end   = f_end && t_end;
    assign out_free   = !r_ovalid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && !o_in_stall;
    assign in_oor     = (i_timeslot >= 8'(nt)) || (i_freqslot >= 8'(nf));

    // Column flags folded in one cell at a time.
    assign s      = r_rd.st;
    assign mac_eq = (r_rd.partner == r_mac);
    always_comb begin
        n_nonfree = r_nonfree | (s != tsgt_pkg::ST_FREE);
        n_res     = r_res | (s == tsgt_pkg::ST_RES);
        n_txl     = r_txl | (s == tsgt_pkg::ST_TX) | (s == tsgt_pkg::ST_PTX);
        n_rxl     = r_rxl | (s == tsgt_pkg::ST_RX) | (s == tsgt_pkg::ST_PRX);
        n_ptxbad  = r_ptxbad |
                    (!((s == tsgt_pkg::ST_FREE) ||
                       (r_share && ((s == tsgt_pkg::ST_RX) || (s == tsgt_pkg::ST_PRX)))) &&
                     !((s == tsgt_pkg::ST_PTX) && mac_eq));
    end

    assign av_tx = r_share ? !(r_res || r_txl) : !r_nonfree;
    assign av_rx = r_share ? !(r_res || r_rxl) : !r_nonfree;

    // Update of the addressed cell.
    always_comb begin
        act_ok = 1'b0;
        act_we = 1'b0;
        act_wd = r_cell;
        unique case (r_cmd)
            tsgt_pkg::CMD_QUERY: begin
                act_ok = 1'b1;
            end
            tsgt_pkg::CMD_PROPOSE: begin
                if (r_kind == tsgt_pkg::ST_PRX) begin
                    act_ok = av_rx && (r_cell.st == tsgt_pkg::ST_FREE);
                end else if (r_kind == tsgt_pkg::ST_PTX) begin
                    act_ok = !(r_share && (r_cell.st != tsgt_pkg::ST_FREE)) && !r_ptxbad;
                end
                act_we = act_ok;
                act_wd = '{st: r_kind, partner: r_mac, last_use: '0, removal: '0};
            end
            tsgt_pkg::CMD_CONFIRM: begin
                act_ok = (((r_kind == tsgt_pkg::ST_TX) && (r_cell.st == tsgt_pkg::ST_PTX)) ||
                          ((r_kind == tsgt_pkg::ST_RX) && (r_cell.st == tsgt_pkg::ST_PRX))) &&
                         (r_cell.partner == r_mac);
                act_we = act_ok;
                act_wd.st       = r_kind;
                act_wd.last_use = r_now;
                act_wd.removal  = '0;
            end
            tsgt_pkg::CMD_RESERVE: begin
                act_ok = !r_nonfree;
                act_we = 1'b1;
                act_wd = '{st: tsgt_pkg::ST_RES, partner: '0, last_use: '0, removal: '0};
            end
            tsgt_pkg::CMD_FREE: begin
                act_ok = 1'b1;
                act_we = 1'b1;
                act_wd = '0;
            end
            tsgt_pkg::CMD_MARK_RM: begin
                act_ok = ((r_cell.st == tsgt_pkg::ST_TX) || (r_cell.st == tsgt_pkg::ST_RX)) &&
                         (r_cell.removal == '0);
                act_we = act_ok;
                act_wd.removal = r_rid;
            end
            tsgt_pkg::CMD_UPDATE: begin
                act_ok = (r_cell.st == tsgt_pkg::ST_TX) || (r_cell.st == tsgt_pkg::ST_RX);
                act_we = act_ok;
                act_wd.last_use = r_now;
            end
            default: begin
                act_ok = 1'b0;
            end
        endcase
    end

    // Sweep match and idle test on the cell just read.
    always_comb begin
        sw_wd = '0;
        case (r_cmd)
            tsgt_pkg::CMD_ABORT_RM, tsgt_pkg::CMD_EXEC_RM:
                sw_hit = (r_rid != '0) && (r_rd.removal == r_rid);
            tsgt_pkg::CMD_ABORT_RX:
                sw_hit = (s == tsgt_pkg::ST_PRX) && mac_eq;
            default:
                sw_hit = (s == tsgt_pkg::ST_PTX) && mac_eq;
        endcase
        if (r_cmd == tsgt_pkg::CMD_ABORT_RM) begin
            sw_wd = r_rd;
            sw_wd.removal = '0;
        end
        lim      = {16'b0, (s == tsgt_pkg::ST_RX) ? r_rx_to : r_tx_to};
        idle_age = r_now - r_rd.last_use;
        idle_hit = ((s == tsgt_pkg::ST_TX) || (s == tsgt_pkg::ST_RX)) &&
                   (r_rd.removal == '0) && (idle_age >= lim);
    end

    // Result words.
    always_comb begin
        res_rep = '0;
        res_rep.ok   = r_ok;
        res_rep.oor  = r_oor;
        res_rep.ft   = 3'(r_ft);
        res_rep.ff   = 3'(r_ff);
        res_rep.last = 1'b1;
        if (r_have) begin
            res_rep.status   = r_cell.st;
            res_rep.partner  = r_cell.partner;
            res_rep.rm_pend  = (r_cell.removal != '0);
            res_rep.av_tx    = (r_cell.st == tsgt_pkg::ST_FREE) && av_tx;
            res_rep.av_rx    = (r_cell.st == tsgt_pkg::ST_FREE) && av_rx;
            res_rep.col_free = !r_nonfree;
        end
        // An idle cell is allocated, so it is never free and its column never empty.
        res_idle = '0;
        res_idle.ok      = 1'b1;
        res_idle.status  = r_rd.st;
        res_idle.partner = r_rd.partner;
        res_idle.ft      = 3'(r_t);
        res_idle.ff      = 3'(r_f);
    end

    // Result register load.
    always_comb begin
        out_load = 1'b0;
        out_word = res_rep;
        unique case (r_state)
            S_OUT: begin
                out_load = out_free;
            end
            S_IEV: begin
                out_load = idle_hit && r_pv && out_free;
                out_word = r_pend;
            end
            S_IFIN: begin
                out_load = out_free;
                if (r_pv) begin
                    out_word      = r_pend;
                    out_word.last = 1'b1;
                end
            end
            default: begin
                out_load = 1'b0;
            end
        endcase
    end

    // Memory port control.
    always_comb begin
        mem_we = 1'b0;
        mem_wa = cix(r_t, r_f);
        mem_wd = '0;
        rd_en  = 1'b0;
        rd_a   = cix(r_t, r_f);
        unique case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = r_clr;
            end
            S_ACT: begin
                mem_we = act_we;
                mem_wa = cix(r_tt, r_tf);
                mem_wd = act_wd;
            end
            S_SEV: begin
                mem_we = sw_hit;
                mem_wd = sw_wd;
            end
            S_CRD, S_RRD: begin
                rd_en = 1'b1;
                rd_a  = cix(r_tt, r_f);
            end
            S_SRD, S_IRD: begin
                rd_en = 1'b1;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (rd_en) begin
            r_rd <= mem[rd_a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used_t <= 4'd8;
            r_used_f <= 4'd8;
            r_tx_to  <= '0;
            r_rx_to  <= '0;
            r_share  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tsgt_pkg::CFG_USED_T: r_used_t <= i_cfg_data[3:0];
                tsgt_pkg::CFG_USED_F: r_used_f <= i_cfg_data[3:0];
                tsgt_pkg::CFG_TX_TO:  r_tx_to  <= i_cfg_data;
                tsgt_pkg::CFG_RX_TO:  r_rx_to  <= i_cfg_data;
                tsgt_pkg::CFG_SHARE:  r_share  <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Result register: a new word is loaded only when the old one is gone or leaving.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_load) begin
            r_out    <= out_word;
            r_ovalid <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_pv     <= 1'b0;
            r_cnt    <= '0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + CW'(1);
                    if (r_clr == CW'(CELLS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_cmd     <= i_command;
                        r_kind    <= i_slot_kind;
                        r_mac     <= i_partner_id;
                        r_rid     <= i_removal_id;
                        r_now     <= i_now_ns;
                        r_t       <= '0;
                        r_f       <= '0;
                        r_ft      <= '0;
                        r_ff      <= '0;
                        r_found   <= 1'b0;
                        r_ok      <= 1'b0;
                        r_oor     <= 1'b0;
                        r_have    <= 1'b0;
                        r_nonfree <= 1'b0;
                        r_res     <= 1'b0;
                        r_txl     <= 1'b0;
                        r_rxl     <= 1'b0;
                        r_ptxbad  <= 1'b0;
                        r_pv      <= 1'b0;
                        r_cnt     <= '0;
                        case (i_command) inside
                            [tsgt_pkg::CMD_QUERY:tsgt_pkg::CMD_UPDATE]: begin
                                r_tt <= TW'(i_timeslot);
                                r_tf <= FW'(i_freqslot);
                                if (in_oor) begin
                                    r_oor   <= 1'b1;
                                    r_state <= S_OUT;
                                end else begin
                                    r_state <= S_CRD;
                                end
                            end
                            [tsgt_pkg::CMD_ABORT_RM:tsgt_pkg::CMD_EXEC_RM]: begin
                                r_state <= grid_empty ? S_OUT : S_SRD;
                            end
                            tsgt_pkg::CMD_IDLE_SCAN: begin
                                r_state <= grid_empty ? S_IFIN : S_IRD;
                            end
                            default: begin
                                r_state <= S_OUT;
                            end
                        endcase
                    end
                end
                S_CRD, S_RRD: begin
                    r_state <= (r_state == S_CRD) ? S_CEV : S_REV;
                end
                S_CEV, S_REV: begin
                    r_nonfree <= n_nonfree;
                    r_res     <= n_res;
                    r_txl     <= n_txl;
                    r_rxl     <= n_rxl;
                    r_ptxbad  <= n_ptxbad;
                    if (r_f == r_tf) begin
                        r_cell <= r_rd;
                    end
                    if (f_end) begin
                        r_state <= (r_state == S_CEV) ? S_ACT : S_OUT;
                    end else begin
                        r_f     <= r_f + FW'(1);
                        r_state <= (r_state == S_CEV) ? S_CRD : S_RRD;
                    end
                end
                S_ACT: begin
                    // The column is walked again so the reply shows the updated timeslot.
                    r_ok      <= act_ok;
                    r_have    <= 1'b1;
                    r_f       <= '0;
                    r_nonfree <= 1'b0;
                    r_res     <= 1'b0;
                    r_txl     <= 1'b0;
                    r_rxl     <= 1'b0;
                    r_ptxbad  <= 1'b0;
                    r_state   <= S_RRD;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_state  <= S_IDLE;
                    end
                end
                S_SRD: begin
                    r_state <= S_SEV;
                end
                S_SEV: begin
                    if (sw_hit && !r_found) begin
                        r_ft    <= r_t;
                        r_ff    <= r_f;
                        r_found <= 1'b1;
                        r_ok    <= 1'b1;
                        r_have  <= 1'b1;
                    end
                    if ((sw_hit && (r_cmd != tsgt_pkg::CMD_ABORT_TX)) ||
                        (cell_end && (r_found || sw_hit))) begin
                        r_tt      <= (r_found) ? r_ft : r_t;
                        r_tf      <= (r_found) ? r_ff : r_f;
                        r_f       <= '0;
                        r_nonfree <= 1'b0;
                        r_res     <= 1'b0;
                        r_txl     <= 1'b0;
                        r_rxl     <= 1'b0;
                        r_ptxbad  <= 1'b0;
                        r_state   <= S_RRD;
                    end else if (cell_end) begin
                        r_state <= S_OUT;
                    end else begin
                        if (f_end) begin
                            r_f <= '0;
                            r_t <= r_t + TW'(1);
                        end else begin
                            r_f <= r_f + FW'(1);
                        end
                        r_state <= S_SRD;
                    end
                end
                S_IRD: begin
                    r_state <= S_IEV;
                end
                S_IEV: begin
                    // A hit waits here while the previous one cannot leave.
                    if (!(idle_hit && r_pv && !out_free)) begin
                        if (idle_hit) begin
                            r_pend <= res_idle;
                            r_pv   <= 1'b1;
                            r_cnt  <= r_cnt + tsgt_pkg::CNT_W'(1);
                        end
                        if ((idle_hit &&
                             (r_cnt + tsgt_pkg::CNT_W'(1) ==
                              tsgt_pkg::CNT_W'(tsgt_pkg::MAX_RESULTS))) || cell_end) begin
                            r_state <= S_IFIN;
                        end else begin
                            if (f_end) begin
                                r_f <= '0;
                                r_t <= r_t + TW'(1);
                            end else begin
                                r_f <= r_f + FW'(1);
                            end
                            r_state <= S_IRD;
                        end
                    end
                end
                S_IFIN: begin
                    if (out_free) begin
                        r_pv     <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid       = r_ovalid;
    assign o_ok              = r_out.ok;
    assign o_out_of_range    = r_out.oor;
    assign o_slot_status     = r_out.status;
    assign o_slot_partner    = r_out.partner;
    assign o_removal_pending = r_out.rm_pend;
    assign o_avail_tx        = r_out.av_tx;
    assign o_avail_rx        = r_out.av_rx;
    assign o_column_free     = r_out.col_free;
    assign o_found_timeslot  = r_out.ft;
    assign o_found_freqslot  = r_out.ff;
    assign o_last            = r_out.last;

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !mem_we)
        else $error("cell memory written while idle");

    a_busy_after_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request accepted without the sequencer going busy");

    a_result_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= tsgt_pkg::CNT_W'(tsgt_pkg::MAX_RESULTS))
        else $error("idle scan counted past the result limit");

    a_no_result_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !r_ovalid)
        else $error("result shown during the clearing pass");

endmodule
